@@ hw/rtl/srtt_pkg.sv @@
// ----------------------------------------------------------------------------
// srtt_pkg
// Shared types, codes and mask helpers for the shadow register taint tracker.
// ----------------------------------------------------------------------------
package srtt_pkg;

  localparam int unsigned NumRegsDef  = 16;
  localparam int unsigned StackRegDef = 4;
  localparam int unsigned FrameRegDef = 5;
  localparam logic [63:0] Lower32Mask = 64'h0000_0000_ffff_ffff;

  typedef enum logic [3:0] {
    OP_COPY      = 4'd0,
    OP_CHECK     = 4'd1,
    OP_LOAD      = 4'd2,
    OP_CHKFLAGS  = 4'd3,
    OP_SETFLAGS  = 4'd4,
    OP_INITSTACK = 4'd5,
    OP_STORE     = 4'd6,
    OP_QREG      = 4'd7,
    OP_QREGREG   = 4'd8,
    OP_QREGMEM   = 4'd9,
    OP_SETRANGE  = 4'd10,
    OP_CLRUPPER  = 4'd11,
    OP_ORRR      = 4'd12,
    OP_ORRM      = 4'd13,
    OP_ORMR      = 4'd14,
    OP_NOP       = 4'd15
  } srtt_op_e;

  typedef enum logic [2:0] {
    W_BYTE  = 3'd0,
    W_HIGH  = 3'd1,
    W_WORD  = 3'd2,
    W_DWORD = 3'd3,
    W_QWORD = 3'd4
  } srtt_width_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_EXEC = 2'd2,
    ST_OUT  = 2'd3
  } srtt_state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch the request
    logic execute;  // compute result and write back
  } srtt_cmd_t;

  // Length mask for a width code; codes above qword act as qword.
  function automatic logic [63:0] len_mask(input logic [2:0] c);
    logic [63:0] m;
    case (c)
      W_BYTE, W_HIGH: m = 64'hff;
      W_WORD:         m = 64'hffff;
      W_DWORD:        m = Lower32Mask;
      default:        m = '1;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] offs(input logic [2:0] c);
    return (c == W_HIGH) ? 6'd8 : 6'd0;
  endfunction

  function automatic logic [3:0] nbytes(input logic [2:0] c);
    logic [3:0] n;
    case (c)
      W_BYTE, W_HIGH: n = 4'd1;
      W_WORD:         n = 4'd2;
      W_DWORD:        n = 4'd4;
      default:        n = 4'd8;
    endcase
    return n;
  endfunction

  function automatic logic [63:0] range_mask(input logic [2:0] c);
    return len_mask(c) << offs(c);
  endfunction

  function automatic logic [63:0] ext(input logic [63:0] v, input logic [2:0] c);
    return (v >> offs(c)) & len_mask(c);
  endfunction

endpackage

@@ hw/rtl/srtt_ctrl.sv @@
// ----------------------------------------------------------------------------
// srtt_ctrl
// Sequencer: accept a request, read the shadows, execute, hold the result.
// ----------------------------------------------------------------------------
module srtt_ctrl
  import srtt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output srtt_cmd_t cmd_o
);

  srtt_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_READ;
        end
      end
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: begin
        cmd_o.execute = 1'b1;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_exec_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |=> cmd_o.execute) else $error("execute did not follow read");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("accept while result pending");
  a_out_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.execute |=> out_valid_o) else $error("no result after execute");
`endif

endmodule

@@ hw/rtl/srtt_datapath.sv @@
// ----------------------------------------------------------------------------
// srtt_datapath
// Shadow register file, flags bit and the operation logic.
// ----------------------------------------------------------------------------
module srtt_datapath
  import srtt_pkg::*;
#(
  parameter int unsigned NumRegs  = NumRegsDef,
  parameter int unsigned StackReg = StackRegDef,
  parameter int unsigned FrameReg = FrameRegDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  srtt_cmd_t   cmd_i,
  input  logic [3:0]  opcode_i,
  input  logic [3:0]  dest_reg_i,
  input  logic [2:0]  dest_width_i,
  input  logic [3:0]  src_reg_i,
  input  logic [2:0]  src_width_i,
  input  logic [63:0] mem_shadow_i,
  input  logic        is_app_address_i,
  input  logic        flag_value_i,
  output logic        warning_o,
  output logic        fully_defined_o,
  output logic [63:0] mem_shadow_out_o,
  output logic        mem_write_o,
  output logic [3:0]  mem_byte_count_o
);

  localparam int unsigned IdxW = (NumRegs > 1) ? $clog2(NumRegs) : 1;
  localparam logic [IdxW-1:0] StackIdx = IdxW'(StackReg % NumRegs);
  localparam logic [IdxW-1:0] FrameIdx = IdxW'(FrameReg % NumRegs);

  logic [63:0]     regs_q [NumRegs];
  logic [NumRegs-1:0] vld_q;
  logic            flags_q;

  srtt_op_e        op_q;
  logic [IdxW-1:0] d_q, s_q;
  logic [2:0]      dc_q, sc_q;
  logic [63:0]     mem_q;
  logic            app_q, fv_q;
  logic [63:0]     dv_q, sv_q;

  logic            warn_q, fully_q, mwr_q;
  logic [63:0]     mout_q;
  logic [3:0]      mcnt_q;

  // register index wraps modulo the register count (compare and subtract)
  function automatic logic [IdxW-1:0] ridx(input logic [3:0] r);
    logic [4:0] v;
    v = {1'b0, r};
    for (int i = 0; i < 8; i++) begin
      if (32'(v) >= NumRegs) v = v - 5'(NumRegs);
    end
    return IdxW'(v);
  endfunction

  // capture request fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= srtt_op_e'(opcode_i);
      d_q   <= ridx(dest_reg_i);
      s_q   <= ridx(src_reg_i);
      dc_q  <= (dest_width_i > W_QWORD) ? W_QWORD : dest_width_i;
      sc_q  <= (src_width_i > W_QWORD) ? W_QWORD : src_width_i;
      mem_q <= mem_shadow_i;
      app_q <= is_app_address_i;
      fv_q  <= flag_value_i;
    end
  end

  // read stage: fetch both operand shadows (unwritten entries read all ones)
  always_ff @(posedge clk_i) begin
    dv_q <= vld_q[d_q] ? regs_q[d_q] : '1;
    sv_q <= vld_q[s_q] ? regs_q[s_q] : '1;
  end

  // execute
  logic [63:0] lm, rmd, rms, nv, sx, mm;
  logic        wr_en, wr_fl, fl_val, warn_d, fully_d, mwr_d, ist;
  logic [63:0] mout_d;
  logic [3:0]  mcnt_d;

  always_comb begin
    lm      = len_mask(dc_q);
    rmd     = range_mask(dc_q);
    rms     = range_mask(sc_q);
    sx      = ext(sv_q, sc_q);
    mm      = mem_q & lm;
    nv      = dv_q;
    wr_en   = 1'b0;
    wr_fl   = 1'b0;
    fl_val  = 1'b0;
    warn_d  = 1'b0;
    fully_d = 1'b0;
    mout_d  = '0;
    mwr_d   = 1'b0;
    mcnt_d  = '0;
    ist     = 1'b0;
    case (op_q)
      OP_COPY: begin
        nv    = (dv_q & ~rmd) | (((sv_q >> offs(sc_q)) & lm) << offs(dc_q));
        wr_en = 1'b1;
      end
      OP_CHECK:    warn_d = |(dv_q & rmd);
      OP_LOAD: begin
        nv    = (dv_q & ~rmd) | (mm << offs(dc_q));
        wr_en = app_q;
      end
      OP_CHKFLAGS: warn_d = !flags_q;
      OP_SETFLAGS: begin
        wr_fl  = 1'b1;
        fl_val = fv_q;
      end
      OP_INITSTACK: ist = 1'b1;
      OP_STORE: begin
        mout_d = ext(dv_q, dc_q);
        mwr_d  = 1'b1;
        mcnt_d = nbytes(dc_q);
      end
      OP_QREG:     fully_d = ~|(dv_q & rmd);
      OP_QREGREG: begin
        if (dc_q == W_HIGH || sc_q == W_HIGH) begin
          fully_d = ~|(dv_q & rmd) && ~|(sv_q & rms);
        end else begin
          fully_d = ~|((dv_q | sv_q) & lm);
        end
      end
      OP_QREGMEM:  fully_d = ~|mm && ~|(dv_q & rmd);
      OP_SETRANGE: begin
        nv    = fv_q ? (dv_q & ~rmd) : (dv_q | rmd);
        wr_en = 1'b1;
      end
      OP_CLRUPPER: begin
        nv    = dv_q & Lower32Mask;
        wr_en = 1'b1;
      end
      OP_ORRR, OP_ORRM: begin
        if (dc_q == W_QWORD) begin
          nv = dv_q | ((op_q == OP_ORRR) ? sx : mm);
        end else if (dc_q == W_DWORD) begin
          nv = (dv_q | ((op_q == OP_ORRR) ? sx : mm)) & Lower32Mask;
        end else begin
          nv = dv_q | ((((op_q == OP_ORRR) ? sx : mm) & lm) << offs(dc_q));
        end
        wr_en  = 1'b1;
        wr_fl  = 1'b1;
        fl_val = ~|nv;
      end
      OP_ORMR: begin
        mout_d = mm | ext(dv_q, dc_q);
        mwr_d  = 1'b1;
        mcnt_d = nbytes(dc_q);
        wr_fl  = 1'b1;
        fl_val = ~|mout_d;
      end
      default: ;
    endcase
  end

  // register file and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      flags_q <= 1'b1;
    end else if (cmd_i.execute) begin
      if (wr_fl) flags_q <= fl_val;
      if (wr_en) vld_q[d_q] <= 1'b1;
      if (ist) begin
        vld_q[StackIdx] <= 1'b1;
        vld_q[FrameIdx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      if (wr_en) regs_q[d_q] <= nv;
      if (ist) begin
        regs_q[StackIdx] <= '0;
        regs_q[FrameIdx] <= '0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      warn_q  <= warn_d;
      fully_q <= fully_d;
      mout_q  <= mout_d;
      mwr_q   <= mwr_d;
      mcnt_q  <= mcnt_d;
    end
  end

  assign warning_o        = warn_q;
  assign fully_defined_o  = fully_q;
  assign mem_shadow_out_o = mout_q;
  assign mem_write_o      = mwr_q;
  assign mem_byte_count_o = mcnt_q;

`ifndef SYNTHESIS
  a_initstack_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.execute && ist |=> vld_q[StackIdx] && vld_q[FrameIdx])
    else $error("init stack left registers invalid");
  a_setflags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.execute && op_q == OP_SETFLAGS |=> flags_q == $past(fv_q))
    else $error("flags not written");
  a_write_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.execute && !mwr_d |=> mcnt_q == 4'd0)
    else $error("byte count without write");
`endif

endmodule

@@ hw/rtl/shadow_register_taint_tracker_core.sv @@
// ----------------------------------------------------------------------------
// shadow_register_taint_tracker_core
// Tracks undefined-bit shadows of the register file and a flags bit.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  in      | in_valid_i/ready_o | opcode_i .. flag_value_i
//  out     | out_valid_o/ready_i| warning_o .. mem_byte_count_o
//
// Each request passes through accept and capture, shadow read and execute,
// then the result is offered from the output register; the next request is
// accepted in the cycle after the result leaves.
// One request is in flight at a time; the register file read is registered.
// Reset sets all shadows to undefined and the flags bit to defined.
// A stalled output holds the result and blocks the next request.
module shadow_register_taint_tracker_core
  import srtt_pkg::*;
#(
  parameter int unsigned NumRegs  = NumRegsDef,
  parameter int unsigned StackReg = StackRegDef,
  parameter int unsigned FrameReg = FrameRegDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  opcode_i,
  input  logic [3:0]  dest_reg_i,
  input  logic [2:0]  dest_width_i,
  input  logic [3:0]  src_reg_i,
  input  logic [2:0]  src_width_i,
  input  logic [63:0] mem_shadow_i,
  input  logic        is_app_address_i,
  input  logic        flag_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        warning_o,
  output logic        fully_defined_o,
  output logic [63:0] mem_shadow_out_o,
  output logic        mem_write_o,
  output logic [3:0]  mem_byte_count_o
);

  srtt_cmd_t cmd;

  srtt_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .out_valid_o,
    .out_ready_i,
    .cmd_o (cmd)
  );

  srtt_datapath #(
    .NumRegs  (NumRegs),
    .StackReg (StackReg),
    .FrameReg (FrameReg)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i (cmd),
    .opcode_i,
    .dest_reg_i,
    .dest_width_i,
    .src_reg_i,
    .src_width_i,
    .mem_shadow_i,
    .is_app_address_i,
    .flag_value_i,
    .warning_o,
    .fully_defined_o,
    .mem_shadow_out_o,
    .mem_write_o,
    .mem_byte_count_o
  );

endmodule

@@ tb/tb_shadow_register_taint_tracker_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_shadow_register_taint_tracker_core
// Drives instrumented operations into the taint tracker core, predicts each
// result from a private copy of the register shadows and flags bit, and
// compares every result field with the oldest expectation.
// ----------------------------------------------------------------------------
module tb_shadow_register_taint_tracker_core;
  import srtt_pkg::*;

  localparam int unsigned NRegs     = NumRegsDef;
  localparam int unsigned StkReg    = StackRegDef;
  localparam int unsigned FrmReg    = FrameRegDef;
  localparam int unsigned CycLimit  = 400000;

  typedef struct packed {
    logic        warning;
    logic        fully;
    logic [63:0] mout;
    logic        mwr;
    logic [3:0]  mcnt;
  } taint_res_t;

  typedef struct packed {
    srtt_op_e    op;
    logic [3:0]  dreg;
    logic [2:0]  dw;
    logic [3:0]  sreg;
    logic [2:0]  sw;
    logic [63:0] mem;
    logic        app;
    logic        fv;
  } taint_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [3:0]  opcode_i = '0;
  logic [3:0]  dest_reg_i = '0;
  logic [2:0]  dest_width_i = '0;
  logic [3:0]  src_reg_i = '0;
  logic [2:0]  src_width_i = '0;
  logic [63:0] mem_shadow_i = '0;
  logic        is_app_address_i = 1'b0;
  logic        flag_value_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        warning_o;
  logic        fully_defined_o;
  logic [63:0] mem_shadow_out_o;
  logic        mem_write_o;
  logic [3:0]  mem_byte_count_o;

  // predictor state
  logic [63:0] shadow_regs [NRegs];
  logic        flags_def;
  taint_res_t  pending_results [$];

  int unsigned errors = 0;
  int unsigned sent = 0;
  int unsigned checked = 0;
  int unsigned cycles = 0;
  bit          hold_rx = 1'b0;
  bit          burst_mode = 1'b0;

  always #6 clk_i = ~clk_i;

  shadow_register_taint_tracker_core uut (.*);

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [63:0] wmask(logic [2:0] c);
    case (c)
      W_BYTE, W_HIGH: return 64'hff;
      W_WORD:         return 64'hffff;
      W_DWORD:        return 64'h0000_0000_ffff_ffff;
      default:        return '1;
    endcase
  endfunction

  function automatic int wshift(logic [2:0] c);
    return (c == W_HIGH) ? 8 : 0;
  endfunction

  function automatic logic [3:0] wbytes(logic [2:0] c);
    case (c)
      W_BYTE, W_HIGH: return 4'd1;
      W_WORD:         return 4'd2;
      W_DWORD:        return 4'd4;
      default:        return 4'd8;
    endcase
  endfunction

  // work out the result of one request and update the shadow copy
  function automatic taint_res_t predict_taint(taint_req_t q);
    taint_res_t  r;
    logic [2:0]  dc, sc;
    logic [63:0] lm, rm, srm, nv, sv;
    int          d, s;
    r  = '0;
    dc = (q.dw > 3'd4) ? 3'd4 : q.dw;
    sc = (q.sw > 3'd4) ? 3'd4 : q.sw;
    d  = q.dreg % NRegs;
    s  = q.sreg % NRegs;
    lm = wmask(dc);
    rm = lm << wshift(dc);
    srm = wmask(sc) << wshift(sc);
    sv = (shadow_regs[s] >> wshift(sc)) & wmask(sc);
    case (q.op)
      OP_COPY: shadow_regs[d] = (shadow_regs[d] & ~rm) |
                                (((shadow_regs[s] >> wshift(sc)) & lm) << wshift(dc));
      OP_CHECK: r.warning = (shadow_regs[d] & rm) != 0;
      OP_LOAD: if (q.app) shadow_regs[d] = (shadow_regs[d] & ~rm) | ((q.mem & lm) << wshift(dc));
      OP_CHKFLAGS: r.warning = !flags_def;
      OP_SETFLAGS: flags_def = q.fv;
      OP_INITSTACK: begin
        shadow_regs[StkReg % NRegs] = '0;
        shadow_regs[FrmReg % NRegs] = '0;
      end
      OP_STORE: begin
        r.mout = (shadow_regs[d] >> wshift(dc)) & lm;
        r.mwr  = 1'b1;
        r.mcnt = wbytes(dc);
      end
      OP_QREG: r.fully = (shadow_regs[d] & rm) == 0;
      OP_QREGREG:
        if (dc == W_HIGH || sc == W_HIGH)
          r.fully = ((shadow_regs[d] & rm) == 0) && ((shadow_regs[s] & srm) == 0);
        else
          r.fully = ((shadow_regs[d] | shadow_regs[s]) & lm) == 0;
      OP_QREGMEM: r.fully = ((q.mem & lm) == 0) && ((shadow_regs[d] & rm) == 0);
      OP_SETRANGE:
        if (q.fv) shadow_regs[d] &= ~rm;
        else shadow_regs[d] |= rm;
      OP_CLRUPPER: shadow_regs[d] &= 64'h0000_0000_ffff_ffff;
      OP_ORRR, OP_ORRM: begin
        nv = (q.op == OP_ORRR) ? sv : (q.mem & lm);
        if (dc == W_QWORD) nv = shadow_regs[d] | nv;
        else if (dc == W_DWORD) nv = (shadow_regs[d] | nv) & 64'h0000_0000_ffff_ffff;
        else nv = shadow_regs[d] | ((nv & lm) << wshift(dc));
        shadow_regs[d] = nv;
        flags_def = (nv == 0);
      end
      OP_ORMR: begin
        nv = (q.mem & lm) | ((shadow_regs[d] >> wshift(dc)) & lm);
        r.mout = nv;
        r.mwr  = 1'b1;
        r.mcnt = wbytes(dc);
        flags_def = (nv == 0);
      end
      default: ;
    endcase
    return r;
  endfunction

  // send one request, with a random gap unless bursting; valid stays up
  // between back-to-back requests and drops only before a gap
  task automatic send_request(taint_req_t q);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    opcode_i         <= q.op;
    dest_reg_i       <= q.dreg;
    dest_width_i     <= q.dw;
    src_reg_i        <= q.sreg;
    src_width_i      <= q.sw;
    mem_shadow_i     <= q.mem;
    is_app_address_i <= q.app;
    flag_value_i     <= q.fv;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(predict_taint(q));
    sent++;
  endtask

  // receiver: random stalls, long hold-off on request
  initial begin
    int stall;
    forever begin
      @(posedge clk_i);
      if (hold_rx) out_ready_i <= 1'b0;
      else begin
        stall = $urandom_range(0, 5);
        if (stall == 0 || $urandom_range(0, 2) == 0) out_ready_i <= 1'b1;
        else begin
          out_ready_i <= 1'b0;
          repeat (stall - 1) @(posedge clk_i);
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    taint_res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = pending_results.pop_front();
        checked++;
        if (warning_o !== e.warning) begin
          $error("warning exp %0h got %0h", e.warning, warning_o); errors++;
        end
        if (fully_defined_o !== e.fully) begin
          $error("fully_defined exp %0h got %0h", e.fully, fully_defined_o); errors++;
        end
        if (mem_shadow_out_o !== e.mout) begin
          $error("mem_shadow_out exp %h got %h", e.mout, mem_shadow_out_o); errors++;
        end
        if (mem_write_o !== e.mwr) begin
          $error("mem_write exp %0h got %0h", e.mwr, mem_write_o); errors++;
        end
        if (mem_byte_count_o !== e.mcnt) begin
          $error("mem_byte_count exp %0d got %0d", e.mcnt, mem_byte_count_o); errors++;
        end
      end
    end
  end

  function automatic logic [63:0] rand_mem();
    logic [63:0] m;
    m = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: m = '0;
      1: m = '1;
      default: ;
    endcase
    return m;
  endfunction

  function automatic taint_req_t rand_request(int op_lo, int op_hi);
    taint_req_t q;
    q.op   = srtt_op_e'(4'($urandom_range(op_lo, op_hi)));
    q.dreg = 4'($urandom_range(0, 15));
    q.dw   = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) :
                                           3'($urandom_range(0, 4));
    q.sreg = 4'($urandom_range(0, 15));
    q.sw   = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) :
                                           3'($urandom_range(0, 4));
    q.mem  = rand_mem();
    q.app  = $urandom_range(0, 3) != 0;
    q.fv   = 1'($urandom_range(0, 1));
    return q;
  endfunction

  function automatic taint_req_t mk(srtt_op_e op, int dr, logic [2:0] dw, int sr,
                                    logic [2:0] sw, logic [63:0] mem, bit app, bit fv);
    taint_req_t q;
    q = '{op, dr[3:0], dw, sr[3:0], sw, mem, app, fv};
    return q;
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // directed: every operation, width extremes, wide codes, nop
  task automatic test_directed();
    send_request(mk(OP_CHECK, 0, W_QWORD, 0, W_BYTE, '0, 1, 0));
    send_request(mk(OP_CHKFLAGS, 0, W_BYTE, 0, W_BYTE, '0, 1, 0));
    send_request(mk(OP_INITSTACK, 0, W_BYTE, 0, W_BYTE, '0, 1, 0));
    send_request(mk(OP_QREG, StkReg, W_QWORD, 0, W_BYTE, '0, 1, 0));
    send_request(mk(OP_LOAD, 1, W_WORD, 0, W_BYTE, 64'h0, 1, 0));
    send_request(mk(OP_LOAD, 2, W_HIGH, 0, W_BYTE, 64'h0, 0, 0));
    send_request(mk(OP_LOAD, 15, 3'd7, 0, W_BYTE, 64'h8000_0000_0000_0001, 1, 0));
    send_request(mk(OP_COPY, 3, W_DWORD, 2, W_HIGH, '0, 1, 0));
    send_request(mk(OP_COPY, 6, W_QWORD, StkReg, 3'd5, '0, 1, 0));
    send_request(mk(OP_STORE, 15, W_QWORD, 0, W_BYTE, '0, 1, 0));
    send_request(mk(OP_STORE, 3, W_HIGH, 0, W_BYTE, '0, 1, 0));
    send_request(mk(OP_QREGREG, FrmReg, W_WORD, 1, W_WORD, '0, 1, 0));
    send_request(mk(OP_QREGREG, FrmReg, W_HIGH, 1, W_BYTE, '0, 1, 0));
    send_request(mk(OP_QREGMEM, StkReg, W_DWORD, 0, W_BYTE, 64'hffff_0000_0000_0000, 1, 0));
    send_request(mk(OP_SETRANGE, 7, W_HIGH, 0, W_BYTE, '0, 1, 1));
    send_request(mk(OP_SETRANGE, StkReg, W_BYTE, 0, W_BYTE, '0, 1, 0));
    send_request(mk(OP_CLRUPPER, 8, W_BYTE, 0, W_BYTE, '0, 1, 0));
    send_request(mk(OP_ORRR, StkReg, W_QWORD, FrmReg, W_QWORD, '0, 1, 0));
    send_request(mk(OP_ORRR, 9, W_DWORD, FrmReg, W_BYTE, '0, 1, 0));
    send_request(mk(OP_ORRM, FrmReg, W_HIGH, 0, W_BYTE, 64'hff00, 1, 0));
    send_request(mk(OP_ORMR, StkReg, W_QWORD, 0, W_BYTE, '1, 1, 0));
    send_request(mk(OP_SETFLAGS, 0, W_BYTE, 0, W_BYTE, '0, 1, 0));
    send_request(mk(OP_CHKFLAGS, 0, W_BYTE, 0, W_BYTE, '0, 1, 0));
    send_request(mk(OP_NOP, 15, 3'd7, 15, 3'd7, '1, 1, 1));
    wait_drained();
  endtask

  // random operations with defining ones mixed in, so shadows reach zero
  task automatic test_random(int n);
    taint_req_t q;
    for (int i = 0; i < n; i++) begin
      q = rand_request(0, 15);
      if ($urandom_range(0, 2) == 0) begin
        q.op  = ($urandom_range(0, 1) != 0) ? OP_SETRANGE : OP_INITSTACK;
        q.fv  = 1'b1;
      end
      send_request(q);
    end
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering requests
  task automatic test_backpressure();
    fork
      begin
        hold_rx = 1'b1;
        repeat (60) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      begin
        burst_mode = 1'b1;
        for (int i = 0; i < 20; i++) send_request(rand_request(0, 15));
        burst_mode = 1'b0;
      end
    join
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < NRegs; i++) shadow_regs[i] = '1;
    flags_def = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(600);
    test_random(650);
    $display("Sent %0d requests, checked %0d results over all opcodes and widths",
             sent, checked);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
